@@ sv/rtam_pkg.sv @@
// Shared types, widths and constants of the thermocouple rate abort monitor.
`default_nettype none

package rtam_pkg;

   // Default geometry
   localparam int CHANNELS_DEFAULT = 5;
   localparam int WINDOW_DEFAULT   = 10;

   // Field widths
   localparam int OP_W        = 1;
   localparam int CH_FIELD_W  = 3;
   localparam int TEMP_W      = 14;
   localparam int DELTA_W     = 15;
   localparam int SUM_OUT_W   = 19;
   localparam int RATE_W      = 21;
   localparam int SPS_W       = 10;
   localparam int COUNT_W     = 8;
   localparam int CAUSE_W     = 5;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 21;

   // Channels 0 to 3 take part in the limit checks
   localparam int RATE_CHANNELS = 4;
   localparam int N_COUNTERS    = 5;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Register reset values
   localparam logic signed [TEMP_W-1:0] OVER_TEMP_LIMIT_RESET = 14'sd8191;
   localparam logic signed [TEMP_W-1:0] TEMP_LIMIT_RESET      = 14'sd8191;
   localparam logic signed [RATE_W-1:0] RATE_LIMIT_RESET      = 21'sd1048575;
   localparam logic [COUNT_W-1:0]       PERSIST_COUNT_RESET   = 8'd5;
   localparam logic [SPS_W-1:0]         SPS_RESET             = 10'd10;

   typedef enum logic [OP_W-1:0] {
      OP_SAMPLE = 1'b0,
      OP_CHECK  = 1'b1
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_OVER_TEMP_LIMIT    = 3'd0,
      CSR_TEMP_LIMIT         = 3'd1,
      CSR_RATE_LIMIT         = 3'd2,
      CSR_PERSIST_COUNT      = 3'd3,
      CSR_SAMPLES_PER_SECOND = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [TEMP_W-1:0]  over_temp_limit;
      logic [TEMP_W-1:0]  temp_limit;
      logic [RATE_W-1:0]  rate_limit;
      logic [COUNT_W-1:0] persist_count;
      logic [SPS_W-1:0]   samples_per_second;
   } cfg_type;

   typedef struct packed {
      logic               abort;
      logic [CAUSE_W-1:0] causes;
   } verdict_type;

endpackage

`default_nettype wire

@@ sv/rtam_if.sv @@
// Valid/ready channel interfaces for request and response beats.
`default_nettype none

interface rtam_req_if;
   logic                                valid;
   logic                                ready;
   logic [rtam_pkg::OP_W-1:0]           operation;
   logic [rtam_pkg::CH_FIELD_W-1:0]     channel;
   logic signed [rtam_pkg::TEMP_W-1:0]  reading;

   modport source (output valid, output operation, output channel, output reading,
                   input ready);
   modport sink   (input valid, input operation, input channel, input reading,
                   output ready);
endinterface

interface rtam_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [rtam_pkg::CH_FIELD_W-1:0]       report_channel;
   logic signed [rtam_pkg::TEMP_W-1:0]    temperature;
   logic signed [rtam_pkg::SUM_OUT_W-1:0] window_delta_sum;
   logic                                  abort;
   logic [rtam_pkg::CAUSE_W-1:0]          abort_causes;

   modport source (output valid, output report_channel, output temperature,
                   output window_delta_sum, output abort, output abort_causes,
                   input ready);
   modport sink   (input valid, input report_channel, input temperature,
                   input window_delta_sum, input abort, input abort_causes,
                   output ready);
endinterface

`default_nettype wire

@@ sv/rtam_window_ram.sv @@
// Delta window memory: one write port, one registered read port.
`default_nettype none

module rtam_window_ram #(
   parameter int DEPTH = rtam_pkg::CHANNELS_DEFAULT * rtam_pkg::WINDOW_DEFAULT,
   parameter int AW    = $clog2(DEPTH),
   parameter int DW    = rtam_pkg::DELTA_W
) (
   input  wire logic                 clock,
   input  wire logic                 rd_en,
   input  wire logic [AW-1:0]        rd_addr,
   output logic signed [DW-1:0]      rd_data,
   input  wire logic                 wr_en,
   input  wire logic [AW-1:0]        wr_addr,
   input  wire logic signed [DW-1:0] wr_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = $signed(rd_data_ff);

endmodule

`default_nettype wire

@@ sv/rtam_check.sv @@
// Limit and rate tests with persistence counters for the abort check.
`default_nettype none

module rtam_check #(
   parameter int CHANNELS = rtam_pkg::CHANNELS_DEFAULT,
   parameter int WINDOW   = rtam_pkg::WINDOW_DEFAULT,
   parameter int SW       = rtam_pkg::DELTA_W + $clog2(WINDOW)
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             fire,
   input  wire rtam_pkg::cfg_type                cfg,
   input  wire logic signed [rtam_pkg::TEMP_W-1:0] temp [rtam_pkg::RATE_CHANNELS],
   input  wire logic signed [SW-1:0]             sum  [rtam_pkg::RATE_CHANNELS],
   output rtam_pkg::verdict_type                 verdict
);

   localparam int LHS_W = SW + rtam_pkg::SPS_W + 1;
   localparam int RHS_W = rtam_pkg::RATE_W + $clog2(WINDOW) + 1;
   localparam int MW    = (LHS_W > RHS_W) ? LHS_W : RHS_W;

   logic signed [rtam_pkg::TEMP_W-1:0] over_limit;
   logic signed [rtam_pkg::TEMP_W-1:0] temp_limit;
   logic signed [rtam_pkg::RATE_W-1:0] rate_limit;
   logic signed [rtam_pkg::SPS_W:0]    sps;
   logic signed [MW-1:0]               rhs;
   logic signed [MW-1:0]               lhs [rtam_pkg::RATE_CHANNELS];
   logic [rtam_pkg::N_COUNTERS-1:0]    fail;
   logic [rtam_pkg::COUNT_W-1:0]       count_ff [rtam_pkg::N_COUNTERS];
   logic [rtam_pkg::COUNT_W-1:0]       count_in [rtam_pkg::N_COUNTERS];
   logic [rtam_pkg::CAUSE_W-1:0]       causes;

   assign over_limit = $signed(cfg.over_temp_limit);
   assign temp_limit = $signed(cfg.temp_limit);
   assign rate_limit = $signed(cfg.rate_limit);
   assign sps        = $signed({1'b0, cfg.samples_per_second});
   assign rhs        = MW'(rate_limit) * MW'(WINDOW);

   // Evaluate the failing conditions; a missing channel never fails
   always_comb begin
      fail = '0;
      for (int i = 0; i < rtam_pkg::RATE_CHANNELS; i++) begin
         lhs[i] = MW'(sum[i]) * MW'(sps);
         if (i < CHANNELS) begin
            if (temp[i] > over_limit) begin
               fail[0] = 1'b1;
            end
            fail[i + 1] = (temp[i] > temp_limit) && (lhs[i] > rhs);
         end
      end
   end

   // Count consecutive failures, saturate, compare with the threshold
   always_comb begin
      for (int k = 0; k < rtam_pkg::N_COUNTERS; k++) begin
         if (!fail[k]) begin
            count_in[k] = '0;
         end else if (count_ff[k] == rtam_pkg::COUNT_MAX) begin
            count_in[k] = count_ff[k];
         end else begin
            count_in[k] = count_ff[k] + 1'b1;
         end
         causes[k] = fail[k] && (count_in[k] >= cfg.persist_count);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < rtam_pkg::N_COUNTERS; k++) begin
            count_ff[k] <= '0;
         end
      end else if (fire) begin
         for (int k = 0; k < rtam_pkg::N_COUNTERS; k++) begin
            count_ff[k] <= count_in[k];
         end
      end
   end

   assign verdict.abort  = |causes;
   assign verdict.causes = causes;

endmodule

`default_nettype wire

@@ sv/thermocouple_rate_abort_monitor_unit.sv @@
// Top level of the thermocouple rate abort monitor.
//
// req_chan carries sample beats (operation 0: channel, reading) and check
// beats (operation 1). rsp_chan returns exactly one beat per request, in order.
// A sample beat returns its channel, the stored reading and the sum of that
// channel's last WINDOW deltas; a check beat returns abort and its causes.
// A response beat passes the read stage and then the output register: the
// accept edge reads the old delta from the window memory, and the edge on
// which the read stage advances updates the sum, writes the memory back and
// loads the output register. While rsp_chan takes its beats, one beat per cycle
// is sustained; the single read port of the window memory sets that figure.
// When rsp_chan stalls, the output register holds and one more beat waits in
// the read stage; req_chan.ready drops only while both are occupied.
// Reset clears all channel state, counters and the register file to their
// defaults; the window memory is qualified by a per-channel wrap flag, so no
// clearing pass is needed. csr_* writes apply at once and are meant for idle
// periods.
`default_nettype none

module thermocouple_rate_abort_monitor_unit #(
   parameter int CHANNELS = rtam_pkg::CHANNELS_DEFAULT,
   parameter int WINDOW   = rtam_pkg::WINDOW_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   rtam_req_if.sink                               req_chan,
   rtam_rsp_if.source                             rsp_chan,
   input  wire logic                              csr_wr_en,
   input  wire logic [rtam_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [rtam_pkg::CSR_DATA_W-1:0]   csr_wr_data
);

   localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int PW    = $clog2(WINDOW);
   localparam int DEPTH = CHANNELS * WINDOW;
   localparam int AW    = $clog2(DEPTH);
   localparam int SW    = rtam_pkg::DELTA_W + $clog2(WINDOW);
   localparam int TW    = rtam_pkg::TEMP_W;
   localparam int DW    = rtam_pkg::DELTA_W;

   // Register file
   rtam_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            rtam_pkg::CSR_OVER_TEMP_LIMIT:
               cfg_in.over_temp_limit = csr_wr_data[TW-1:0];
            rtam_pkg::CSR_TEMP_LIMIT:
               cfg_in.temp_limit = csr_wr_data[TW-1:0];
            rtam_pkg::CSR_RATE_LIMIT:
               cfg_in.rate_limit = csr_wr_data[rtam_pkg::RATE_W-1:0];
            rtam_pkg::CSR_PERSIST_COUNT:
               cfg_in.persist_count = csr_wr_data[rtam_pkg::COUNT_W-1:0];
            rtam_pkg::CSR_SAMPLES_PER_SECOND:
               cfg_in.samples_per_second = csr_wr_data[rtam_pkg::SPS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.over_temp_limit    <= rtam_pkg::OVER_TEMP_LIMIT_RESET;
         cfg_ff.temp_limit         <= rtam_pkg::TEMP_LIMIT_RESET;
         cfg_ff.rate_limit         <= rtam_pkg::RATE_LIMIT_RESET;
         cfg_ff.persist_count      <= rtam_pkg::PERSIST_COUNT_RESET;
         cfg_ff.samples_per_second <= rtam_pkg::SPS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Per-channel state
   logic signed [TW-1:0] last_temp_ff [CHANNELS];
   logic signed [SW-1:0] delta_sum_ff [CHANNELS];
   logic [PW-1:0]        window_pos_ff [CHANNELS];
   logic [CHANNELS-1:0]  full_ff;

   // Read stage
   logic                     s1_valid_ff, s1_valid_in;
   rtam_pkg::op_type         s1_op_ff;
   logic [rtam_pkg::CH_FIELD_W-1:0] s1_ch_ff;
   logic                     s1_in_range_ff;
   logic signed [TW-1:0]     s1_reading_ff;
   logic [CH_W-1:0]          s1_idx_ff;
   logic [AW-1:0]            s1_slot_ff;
   logic                     s1_full_ff;
   logic                     s1_advance;

   // Output register
   logic                                  out_valid_ff, out_valid_in;
   logic [rtam_pkg::CH_FIELD_W-1:0]       out_ch_ff;
   logic signed [TW-1:0]                  out_temp_ff;
   logic signed [rtam_pkg::SUM_OUT_W-1:0] out_sum_ff;
   logic                                  out_abort_ff;
   logic [rtam_pkg::CAUSE_W-1:0]          out_causes_ff;

   // Accept stage
   logic                 req_accept;
   logic                 in_is_sample;
   logic                 in_range;
   logic [CH_W-1:0]      in_idx;
   logic [PW-1:0]        cur_pos;
   logic [PW-1:0]        next_pos;
   logic [AW-1:0]        in_slot;
   logic                 in_touch;

   assign s1_advance     = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_advance;
   assign req_accept     = req_chan.valid && req_chan.ready;

   assign in_is_sample = (rtam_pkg::op_type'(req_chan.operation) == rtam_pkg::OP_SAMPLE);
   assign in_range     = int'(req_chan.channel) < CHANNELS;
   assign in_idx       = CH_W'(req_chan.channel);
   assign in_touch     = req_accept && in_is_sample && in_range;
   assign cur_pos      = in_range ? window_pos_ff[in_idx] : '0;
   assign next_pos     = (cur_pos == PW'(WINDOW - 1)) ? '0 : cur_pos + 1'b1;
   assign in_slot      = AW'(int'(in_idx) * WINDOW + int'(cur_pos));

   // Window memory
   logic                 ram_rd_en;
   logic                 ram_wr_en;
   logic [AW-1:0]        ram_rd_addr;
   logic [AW-1:0]        ram_wr_addr;
   logic signed [DW-1:0] ram_rd_data;
   logic signed [DW-1:0] ram_wr_data;

   assign ram_rd_en   = in_touch;
   assign ram_rd_addr = in_slot;

   rtam_window_ram #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .DW    (DW)
   ) u_window_ram (
      .clock   (clock),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data)
   );

   // Advance the ring position and mark the channel full on wrap
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            window_pos_ff[c] <= '0;
         end
         full_ff <= '0;
      end else if (in_touch) begin
         window_pos_ff[in_idx] <= next_pos;
         if (cur_pos == PW'(WINDOW - 1)) begin
            full_ff[in_idx] <= 1'b1;
         end
      end
   end

   // Capture the beat into the read stage
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_op_ff       <= rtam_pkg::op_type'(req_chan.operation);
         s1_ch_ff       <= req_chan.channel;
         s1_in_range_ff <= in_range;
         s1_reading_ff  <= req_chan.reading;
         s1_idx_ff      <= in_idx;
         s1_slot_ff     <= in_slot;
         s1_full_ff     <= in_range ? full_ff[in_idx] : 1'b0;
      end
   end

   // Update stage: new delta and window sum
   logic signed [DW-1:0] old_delta;
   logic signed [DW-1:0] new_delta;
   logic signed [TW-1:0] s1_last;
   logic signed [SW-1:0] s1_sum;
   logic signed [SW-1:0] new_sum;
   logic                 s1_write;

   assign s1_last   = s1_in_range_ff ? last_temp_ff[s1_idx_ff] : '0;
   assign s1_sum    = s1_in_range_ff ? delta_sum_ff[s1_idx_ff] : '0;
   assign old_delta = s1_full_ff ? ram_rd_data : '0;
   assign new_delta = DW'(s1_reading_ff) - DW'(s1_last);
   assign new_sum   = s1_sum - SW'(old_delta) + SW'(new_delta);
   assign s1_write  = s1_advance && (s1_op_ff == rtam_pkg::OP_SAMPLE) && s1_in_range_ff;

   assign ram_wr_en   = s1_write;
   assign ram_wr_addr = s1_slot_ff;
   assign ram_wr_data = new_delta;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            last_temp_ff[c] <= '0;
            delta_sum_ff[c] <= '0;
         end
      end else if (s1_write) begin
         last_temp_ff[s1_idx_ff] <= s1_reading_ff;
         delta_sum_ff[s1_idx_ff] <= new_sum;
      end
   end

   // Check unit sees channels 0 to 3
   logic signed [TW-1:0] chk_temp [rtam_pkg::RATE_CHANNELS];
   logic signed [SW-1:0] chk_sum  [rtam_pkg::RATE_CHANNELS];
   rtam_pkg::verdict_type verdict;
   logic                  chk_fire;

   for (genvar i = 0; i < rtam_pkg::RATE_CHANNELS; i++) begin : g_chk
      if (i < CHANNELS) begin : g_present
         assign chk_temp[i] = last_temp_ff[i];
         assign chk_sum[i]  = delta_sum_ff[i];
      end else begin : g_absent
         assign chk_temp[i] = '0;
         assign chk_sum[i]  = '0;
      end
   end

   assign chk_fire = s1_advance && (s1_op_ff == rtam_pkg::OP_CHECK);

   rtam_check #(
      .CHANNELS (CHANNELS),
      .WINDOW   (WINDOW),
      .SW       (SW)
   ) u_check (
      .clock   (clock),
      .reset   (reset),
      .fire    (chk_fire),
      .cfg     (cfg_ff),
      .temp    (chk_temp),
      .sum     (chk_sum),
      .verdict (verdict)
   );

   // Output register: load on advance, drop on drain
   always_comb begin
      out_valid_in = out_valid_ff;
      if (s1_advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         if (s1_op_ff == rtam_pkg::OP_CHECK) begin
            out_ch_ff     <= '0;
            out_temp_ff   <= '0;
            out_sum_ff    <= '0;
            out_abort_ff  <= verdict.abort;
            out_causes_ff <= verdict.causes;
         end else begin
            out_ch_ff     <= s1_ch_ff;
            out_temp_ff   <= s1_in_range_ff ? s1_reading_ff : '0;
            out_sum_ff    <= s1_in_range_ff ? rtam_pkg::SUM_OUT_W'(new_sum) : '0;
            out_abort_ff  <= 1'b0;
            out_causes_ff <= '0;
         end
      end
   end

   assign rsp_chan.valid            = out_valid_ff;
   assign rsp_chan.report_channel   = out_ch_ff;
   assign rsp_chan.temperature      = out_temp_ff;
   assign rsp_chan.window_delta_sum = out_sum_ff;
   assign rsp_chan.abort            = out_abort_ff;
   assign rsp_chan.abort_causes     = out_causes_ff;

`ifndef SYNTHESIS
   a_no_slot_collision: assert property (@(posedge clock) disable iff (reset)
      (ram_rd_en && ram_wr_en) |-> (ram_rd_addr != ram_wr_addr))
      else $error("window memory read and write hit the same slot");

   a_advance_loads_output: assert property (@(posedge clock) disable iff (reset)
      s1_advance |=> out_valid_ff)
      else $error("advanced beat did not reach the output register");

   a_abort_matches_causes: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_abort_ff == (out_causes_ff != '0)))
      else $error("abort flag disagrees with its causes");
`endif

endmodule

`default_nettype wire
